FILE: hdl/bbl_pkg.sv
// ----------------------------------------------------------------------------
// bbl_pkg: shared types and constants for the 3x3 RGB box blur
// Pixel packing, queue sizing, command flags, register map and the
// divide-by-nine helper used by the back end.
// ----------------------------------------------------------------------------
package bbl_pkg;

    // Pixel packing: blue in [7:0], green in [15:8], red in [23:16]
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = CH_W * NUM_CH;
    localparam int COLSUM_W = 10;   // three 8-bit values
    localparam int SUM_W    = 12;   // nine 8-bit values

    // Truncating divide by nine: (s * 3641) >> 15 is exact for s <= 2295
    localparam logic [11:0] DIV9_MUL   = 12'd3641;
    localparam int          DIV9_SHIFT = 15;

    // Configuration registers
    localparam int          CFG_W        = 12;
    localparam logic [11:0] RESET_WIDTH  = 12'd640;
    localparam logic [11:0] RESET_HEIGHT = 12'd480;
    localparam logic        REG_FRAME_WIDTH  = 1'b0;
    localparam logic        REG_FRAME_HEIGHT = 1'b1;

    // Request kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Classification of one queued command
    typedef struct packed {
        logic is_pixel;  // pixel: update line stores and window
        logic emit;      // produces a result
        logic interior;  // result is the 3x3 mean
        logic last;      // final result of the frame
        logic rd_lower;  // flush: take the lower line store entry
    } t_cmd_flags;

    localparam int FLAGS_W = $bits(t_cmd_flags);

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [23:0] prod;
        prod = 24'(sum) * 24'(DIV9_MUL);
        return prod[DIV9_SHIFT +: CH_W];
    endfunction

endpackage

FILE: hdl/bbl_front.sv
// ----------------------------------------------------------------------------
// bbl_front: request classification and frame position tracking
// Holds the frame size registers, tracks input and output raster positions
// and turns every accepted request into a queued command (or drops it).
// ----------------------------------------------------------------------------
module bbl_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_wr,
    input  logic                    i_cfg_sel,
    input  logic [31:0]             i_cfg_wdata,
    output logic [31:0]             o_cfg_rdata,
    // incoming request
    input  logic                    i_accept,
    input  logic                    i_mode,
    input  logic [bbl_pkg::PIX_W-1:0] i_px,
    // command push
    output logic                    o_push,
    output bbl_pkg::t_cmd_flags     o_flags,
    output logic [AW-1:0]           o_addr,
    output logic [bbl_pkg::PIX_W-1:0] o_px
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    function automatic logic [31:0] clamp_dim(input logic [11:0] v, input logic [31:0] maxv);
        logic [31:0] r;
        r = {20'd0, v};
        if (v == 12'd0) begin
            r = 32'd1;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    logic [bbl_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [WW-1:0]             r_w;
    logic [HW-1:0]             r_h;
    logic [HW-1:0]             r_in_row, n_in_row;
    logic [AW-1:0]             r_in_col, n_in_col;
    logic [HW-1:0]             r_out_row, n_out_row;
    logic [AW-1:0]             r_out_col, n_out_col;

    logic in_col_last, out_col_last, out_row_last;
    logic primed, interior, row_done, out_done;

    // Readback
    always_comb begin
        case (i_cfg_sel)
            bbl_pkg::REG_FRAME_WIDTH:  o_cfg_rdata = {20'd0, r_cfg_w};
            bbl_pkg::REG_FRAME_HEIGHT: o_cfg_rdata = {20'd0, r_cfg_h};
            default:                   o_cfg_rdata = 32'd0;
        endcase
    end

    // Position flags
    assign in_col_last  = (WW'(r_in_col) + WW'(1)) == r_w;
    assign out_col_last = (WW'(r_out_col) + WW'(1)) == r_w;
    assign out_row_last = (r_out_row + HW'(1)) == r_h;
    assign primed   = (r_in_row >= HW'(2)) || ((r_in_row == HW'(1)) && (r_in_col != '0));
    assign interior = (r_out_row != '0) && !out_row_last && (r_out_col != '0) && !out_col_last;
    assign row_done = r_in_row >= r_h;
    assign out_done = r_out_row >= r_h;

    // Classification and next positions
    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        o_push    = 1'b0;
        o_flags   = '0;
        o_addr    = r_in_col;
        o_px      = i_px;

        if (i_cfg_wr) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
        end else if (i_accept) begin
            if (i_mode == bbl_pkg::MODE_PIXEL) begin
                if (!row_done) begin
                    o_push           = 1'b1;
                    o_flags.is_pixel = 1'b1;
                    o_flags.emit     = primed;
                    o_flags.interior = interior;
                    o_addr           = r_in_col;
                    if (in_col_last) begin
                        n_in_col = '0;
                        n_in_row = r_in_row + HW'(1);
                    end else begin
                        n_in_col = r_in_col + AW'(1);
                    end
                    if (primed) begin
                        if (out_col_last) begin
                            n_out_col = '0;
                            n_out_row = r_out_row + HW'(1);
                        end else begin
                            n_out_col = r_out_col + AW'(1);
                        end
                    end
                end
            end else begin
                // flush: drain one pending result once the frame is in
                if (row_done) begin
                    if (out_done) begin
                        n_in_row  = '0;
                        n_in_col  = '0;
                        n_out_row = '0;
                        n_out_col = '0;
                    end else begin
                        o_push           = 1'b1;
                        o_flags.emit     = 1'b1;
                        o_flags.rd_lower = out_row_last;
                        o_flags.last     = out_row_last && out_col_last;
                        o_addr           = r_out_col;
                        if (out_row_last && out_col_last) begin
                            n_in_row  = '0;
                            n_in_col  = '0;
                            n_out_row = '0;
                            n_out_col = '0;
                        end else if (out_col_last) begin
                            n_out_col = '0;
                            n_out_row = r_out_row + HW'(1);
                        end else begin
                            n_out_col = r_out_col + AW'(1);
                        end
                    end
                end
            end
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= bbl_pkg::RESET_WIDTH;
            r_cfg_h   <= bbl_pkg::RESET_HEIGHT;
            r_w       <= WW'(clamp_dim(bbl_pkg::RESET_WIDTH, 32'(MAX_WIDTH)));
            r_h       <= HW'(clamp_dim(bbl_pkg::RESET_HEIGHT, 32'(MAX_HEIGHT)));
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_sel)
                    bbl_pkg::REG_FRAME_WIDTH: begin
                        r_cfg_w <= i_cfg_wdata[bbl_pkg::CFG_W-1:0];
                        r_w     <= WW'(clamp_dim(i_cfg_wdata[bbl_pkg::CFG_W-1:0],
                                                 32'(MAX_WIDTH)));
                    end
                    bbl_pkg::REG_FRAME_HEIGHT: begin
                        r_cfg_h <= i_cfg_wdata[bbl_pkg::CFG_W-1:0];
                        r_h     <= HW'(clamp_dim(i_cfg_wdata[bbl_pkg::CFG_W-1:0],
                                                 32'(MAX_HEIGHT)));
                    end
                    default: ;
                endcase
            end
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

endmodule

FILE: hdl/bbl_queue.sv
// ----------------------------------------------------------------------------
// bbl_queue: short command queue between front and back
// Four-entry FIFO of packed commands; head is read combinationally.
// ----------------------------------------------------------------------------
module bbl_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_head,
    output logic          o_full,
    output logic          o_empty
);

    logic [DW-1:0]              r_mem [bbl_pkg::QUEUE_DEPTH];
    logic [bbl_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [bbl_pkg::QPTR_W:0]   r_count;

    assign o_full  = r_count == (bbl_pkg::QPTR_W + 1)'(bbl_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bbl_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + bbl_pkg::QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (bbl_pkg::QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (bbl_pkg::QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/bbl_back.sv
// ----------------------------------------------------------------------------
// bbl_back: line stores, 3x3 window and result pipeline
// Stage 1 reads both line stores, writes them back and slides the window
// (column sums); stage 2 holds the nine-value sums; the output stage divides
// by nine or passes the pixel through.
// ----------------------------------------------------------------------------
module bbl_back #(
    parameter int MAX_WIDTH = 2048,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // queue head
    input  logic                      i_empty,
    input  bbl_pkg::t_cmd_flags       i_head_flags,
    input  logic [AW-1:0]             i_head_addr,
    input  logic [bbl_pkg::PIX_W-1:0] i_head_px,
    output logic                      o_pop,
    // result
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [bbl_pkg::PIX_W-1:0] o_out_px,
    output logic                      o_frame_last
);

    localparam int CH_W = bbl_pkg::CH_W;

    logic [bbl_pkg::PIX_W-1:0] r_upper_mem [MAX_WIDTH];
    logic [bbl_pkg::PIX_W-1:0] r_lower_mem [MAX_WIDTH];

    logic                      en, s1_write;
    logic                      r_s1_valid;
    bbl_pkg::t_cmd_flags       r_s1_flags;
    logic [AW-1:0]             r_s1_addr;
    logic [bbl_pkg::PIX_W-1:0] r_s1_px;
    logic [bbl_pkg::PIX_W-1:0] r_rd_up, r_rd_lo, r_byp_up, r_byp_lo;
    logic                      r_byp;
    logic [bbl_pkg::PIX_W-1:0] up_eff, lo_eff;

    // window: middle of newest column plus sums of the two newest columns
    logic [bbl_pkg::PIX_W-1:0]                         r_col2_mid;
    logic [bbl_pkg::NUM_CH-1:0][bbl_pkg::COLSUM_W-1:0] r_col1_sum, r_col2_sum, ncs;
    logic [bbl_pkg::NUM_CH-1:0][bbl_pkg::SUM_W-1:0]    sum9, r_s2_sum;

    logic                      r_s2_valid, r_s2_interior, r_s2_last;
    logic [bbl_pkg::PIX_W-1:0] r_s2_pass, res_px;

    logic                      r_out_valid, r_out_last;
    logic [bbl_pkg::PIX_W-1:0] r_out_px;

    // Pipeline advance
    assign en       = !r_out_valid || !i_out_stall;
    assign o_pop    = en && !i_empty;
    assign s1_write = en && r_s1_valid && r_s1_flags.is_pixel;

    // Line store data with forwarding of the write one step ahead
    assign up_eff = r_byp ? r_byp_up : r_rd_up;
    assign lo_eff = r_byp ? r_byp_lo : r_rd_lo;

    // Line stores
    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            r_upper_mem[r_s1_addr] <= lo_eff;
            r_lower_mem[r_s1_addr] <= r_s1_px;
        end
        if (o_pop) begin
            r_rd_up <= r_upper_mem[i_head_addr];
            r_rd_lo <= r_lower_mem[i_head_addr];
        end
    end

    // Stage 1 command and forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (en) begin
            r_s1_valid <= !i_empty;
            if (!i_empty) begin
                r_byp <= s1_write && (r_s1_addr == i_head_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_flags <= i_head_flags;
            r_s1_addr  <= i_head_addr;
            r_s1_px    <= i_head_px;
            r_byp_up   <= lo_eff;
            r_byp_lo   <= r_s1_px;
        end
    end

    // Column sum of the incoming column and the nine-value sum
    always_comb begin
        for (int ch = 0; ch < bbl_pkg::NUM_CH; ch++) begin
            ncs[ch]  = bbl_pkg::COLSUM_W'(up_eff[ch*CH_W +: CH_W])
                     + bbl_pkg::COLSUM_W'(lo_eff[ch*CH_W +: CH_W])
                     + bbl_pkg::COLSUM_W'(r_s1_px[ch*CH_W +: CH_W]);
            sum9[ch] = bbl_pkg::SUM_W'(r_col1_sum[ch]) + bbl_pkg::SUM_W'(r_col2_sum[ch])
                     + bbl_pkg::SUM_W'(ncs[ch]);
        end
    end

    // Window slide
    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            r_col1_sum <= r_col2_sum;
            r_col2_sum <= ncs;
            r_col2_mid <= lo_eff;
        end
    end

    // Stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_flags.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_interior <= r_s1_flags.is_pixel && r_s1_flags.interior;
            r_s2_last     <= r_s1_flags.last;
            r_s2_sum      <= sum9;
            if (r_s1_flags.is_pixel) begin
                r_s2_pass <= r_col2_mid;
            end else if (r_s1_flags.rd_lower) begin
                r_s2_pass <= lo_eff;
            end else begin
                r_s2_pass <= up_eff;
            end
        end
    end

    // Divide by nine or pass through
    always_comb begin
        for (int ch = 0; ch < bbl_pkg::NUM_CH; ch++) begin
            res_px[ch*CH_W +: CH_W] = r_s2_interior ? bbl_pkg::div9(r_s2_sum[ch])
                                                    : r_s2_pass[ch*CH_W +: CH_W];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_px   <= res_px;
            r_out_last <= r_s2_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_px     = r_out_px;
    assign o_frame_last = r_out_last;

endmodule

FILE: hdl/box_blur_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core: streaming 3x3 box filter over RGB pixels
// Channel     | handshake                      | payload
// input       | i_in_valid / o_in_stall        | i_mode, i_in_blue/green/red
// output      | o_out_valid / i_out_stall      | o_out_blue/green/red, o_frame_last
// config      | psel/penable/pwrite/pready     | paddr, pwdata, prdata
//
// One request per clock sustained while no stall holds the flow; a result
// follows its request through the queue, line store read, sum and divide stages.
// Reset is synchronous; line stores are not cleared and need no sweep.
// An output stall freezes the back pipeline; the four-entry queue then
// fills and o_in_stall rises.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_red,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_red,
    output logic        o_frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = bbl_pkg::FLAGS_W + AW + bbl_pkg::PIX_W;

    logic                      cfg_wr, accept, push, pop, full, empty;
    bbl_pkg::t_cmd_flags       push_flags, head_flags;
    logic [AW-1:0]             push_addr, head_addr;
    logic [bbl_pkg::PIX_W-1:0] push_px, head_px, in_px, out_px;
    logic [DW-1:0]             head_data;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;
    assign in_px      = {i_in_red, i_in_green, i_in_blue};

    // Front: registers, positions, classification
    bbl_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_sel   (paddr[2]),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_px        (in_px),
        .o_push      (push),
        .o_flags     (push_flags),
        .o_addr      (push_addr),
        .o_px        (push_px)
    );

    // Command queue
    bbl_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_flags, push_addr, push_px}),
        .i_pop   (pop),
        .o_head  (head_data),
        .o_full  (full),
        .o_empty (empty)
    );

    assign head_flags = head_data[DW-1 -: bbl_pkg::FLAGS_W];
    assign head_addr  = head_data[bbl_pkg::PIX_W +: AW];
    assign head_px    = head_data[bbl_pkg::PIX_W-1:0];

    // Back: line stores, window, arithmetic, output register
    bbl_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head_flags (head_flags),
        .i_head_addr  (head_addr),
        .i_head_px    (head_px),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_px     (out_px),
        .o_frame_last (o_frame_last)
    );

    assign o_out_blue  = out_px[7:0];
    assign o_out_green = out_px[15:8];
    assign o_out_red   = out_px[23:16];

endmodule
